FILE: hdl/lir_pkg.sv
// Shared constants and types of the linear interpolation resampler.
package lir_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int RATE_BITS     = 16;
    localparam int POS_BITS      = 17;
    localparam int RES_CAP       = 6;
    localparam int CNT_BITS      = 3;
    localparam int STEP_BITS     = $clog2(FRACTION_BITS + 1);
    localparam int DATA_BITS     = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IN_RATE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_RATE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MONO_MODE = 2'd2;

    localparam logic [RATE_BITS-1:0] IN_RATE_RST  = 16'd44100;
    localparam logic [RATE_BITS-1:0] OUT_RATE_RST = 16'd44100;

    // Load and step strobes shared by the divider and the two lanes
    typedef struct packed {
        logic load;
        logic step;
    } t_step_ctl;

endpackage

FILE: hdl/linear_interp_audio_resampler.sv
// Top level of the linear interpolation stereo sample-rate converter.
//
// Each accepted source frame produces zero to six output frames, each one a
// linear blend of the previous and the current frame at the fraction
// position*65536/(output rate); position advances by the input rate per output
// and drops by the output rate once the frame is used up, or restarts at zero
// when the cap cuts the run short. The fraction comes from a bit-serial
// divider, one bit per cycle, and both channels multiply by it in the same
// cycle. An output frame takes a check, sixteen divide-and-accumulate steps
// and an emit; a final check ends the run, and the emit waits while the output
// side stalls. Source frames are taken one at a time; the output register
// holds a finished frame while the next is computed. Writing any of the three
// config registers clears position and the stored frame; write them only
// while idle. No clearing pass is needed after reset.
module linear_interp_audio_resampler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [lir_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [lir_pkg::RATE_BITS-1:0]    i_cfg_data,
    // source frames
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lir_pkg::DATA_BITS-1:0]    s_axis_tdata,  // left_sample, right_sample
    // output frames
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lir_pkg::DATA_BITS-1:0]    m_axis_tdata,  // out_left, out_right
    output logic                             m_axis_tlast   // last_of_run
);
    import lir_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [CNT_BITS-1:0]  CNT_CAP   = CNT_BITS'(RES_CAP);
    localparam logic [CNT_BITS-1:0]  CNT_FINAL = CNT_BITS'(RES_CAP - 1);
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(FRACTION_BITS - 1);

    // control
    logic [1:0]             r_state, n_state;
    logic [CNT_BITS-1:0]    r_count, n_count;
    logic [STEP_BITS-1:0]   r_step, n_step;
    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic                   r_out_valid, n_out_valid;
    // configuration
    logic [RATE_BITS-1:0]   r_src;
    logic [RATE_BITS-1:0]   r_tgt;
    logic                   r_mono;
    // frame storage
    logic [SAMPLE_BITS-1:0] r_prev_l, r_prev_r;
    logic [SAMPLE_BITS-1:0] r_cur_l, r_cur_r;
    logic [SAMPLE_BITS-1:0] r_out_l, r_out_r;
    logic                   r_out_last;

    logic                   w_in_req;
    logic                   w_out_free;
    logic                   w_emit;
    logic                   w_fin;
    logic                   w_pos_lt;
    logic                   w_run;
    logic                   w_cfg_clr;
    logic [POS_BITS-1:0]    w_tgt_ext;
    logic [POS_BITS-1:0]    w_pos_sum;
    logic                   w_last;
    logic                   w_qbit;
    logic [SAMPLE_BITS-1:0] w_y_l, w_y_r;
    t_step_ctl              w_ctl;

    assign w_tgt_ext  = {{(POS_BITS-RATE_BITS){1'b0}}, r_tgt};
    assign w_pos_sum  = r_pos + {{(POS_BITS-RATE_BITS){1'b0}}, r_src};
    assign w_pos_lt   = (r_pos < w_tgt_ext);
    assign w_run      = (r_count != CNT_CAP) && w_pos_lt;
    // last frame of the run when the cap is hit or the next position is at or past the end
    assign w_last     = (r_count == CNT_FINAL) || !(w_pos_sum < w_tgt_ext);

    // clear state on any known register
    assign w_cfg_clr  = i_cfg_we && (i_cfg_index == CFG_IN_RATE
                                     || i_cfg_index == CFG_OUT_RATE
                                     || i_cfg_index == CFG_MONO_MODE);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_req      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_emit        = (r_state == ST_EMIT) && w_out_free;
    assign w_fin         = (r_state == ST_CHECK) && !w_run;

    assign w_ctl.load = (r_state == ST_CHECK) && w_run;
    assign w_ctl.step = (r_state == ST_CALC);

    lir_divider u_div (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_numer (r_pos[RATE_BITS-1:0]),
        .i_denom (r_tgt),
        .o_qbit  (w_qbit)
    );

    lir_lane u_lane_l (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_qbit (w_qbit),
        .i_prev (r_prev_l),
        .i_cur  (r_cur_l),
        .o_y    (w_y_l)
    );

    lir_lane u_lane_r (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_qbit (w_qbit),
        .i_prev (r_prev_r),
        .i_cur  (r_cur_r),
        .o_y    (w_y_r)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_in_req) begin
                    n_count = '0;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_run) begin
                    n_step  = '0;
                    n_state = ST_CALC;
                end else begin
                    // drop one source period, or restart when the cap cut the run short
                    n_pos   = w_pos_lt ? '0 : (r_pos - w_tgt_ext);
                    n_state = ST_IDLE;
                end
            end
            ST_CALC: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_pos       = w_pos_sum;
                    n_count     = r_count + 1'b1;
                    n_state     = ST_CHECK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_cfg_clr) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_src       <= IN_RATE_RST;
            r_tgt       <= OUT_RATE_RST;
            r_mono      <= 1'b0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            // advance the stored frame once its run is done
            if (w_cfg_clr) begin
                r_prev_l <= '0;
                r_prev_r <= '0;
            end else if (w_fin) begin
                r_prev_l <= r_cur_l;
                r_prev_r <= r_cur_r;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IN_RATE:   r_src  <= i_cfg_data;
                    CFG_OUT_RATE:  r_tgt  <= i_cfg_data;
                    CFG_MONO_MODE: r_mono <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload: capture the source frame, hold the finished output frame
    always_ff @(posedge i_clk) begin
        if (w_in_req) begin
            r_cur_l <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_cur_r <= r_mono ? s_axis_tdata[SAMPLE_BITS-1:0]
                              : s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        if (w_emit) begin
            r_out_l    <= w_y_l;
            r_out_r    <= w_y_r;
            r_out_last <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(DATA_BITS-2*SAMPLE_BITS){1'b0}}, r_out_r, r_out_l};
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: hdl/lir_divider.sv
// Bit-serial restoring divider: one fraction bit per step, MSB first.
module lir_divider (
    input  logic                          i_clk,
    input  lir_pkg::t_step_ctl            i_ctl,
    input  logic [lir_pkg::RATE_BITS-1:0] i_numer,
    input  logic [lir_pkg::RATE_BITS-1:0] i_denom,
    output logic                          o_qbit
);
    import lir_pkg::*;

    logic [RATE_BITS-1:0] r_rem;
    logic [RATE_BITS:0]   w_shift;
    logic [RATE_BITS:0]   w_diff;

    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, i_denom};
    assign o_qbit  = (w_shift >= {1'b0, i_denom});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= i_numer;
        end else if (i_ctl.step) begin
            // remainder stays below the divisor, so the top bit drops
            r_rem <= o_qbit ? w_diff[RATE_BITS-1:0] : w_shift[RATE_BITS-1:0];
        end
    end

endmodule

FILE: hdl/lir_lane.sv
// One channel: serial multiply of the sample step by the fraction, then the sum.
module lir_lane (
    input  logic                            i_clk,
    input  lir_pkg::t_step_ctl              i_ctl,
    input  logic                            i_qbit,
    input  logic [lir_pkg::SAMPLE_BITS-1:0] i_prev,
    input  logic [lir_pkg::SAMPLE_BITS-1:0] i_cur,
    output logic [lir_pkg::SAMPLE_BITS-1:0] o_y
);
    import lir_pkg::*;

    logic [SAMPLE_BITS-1:0]               r_mag;
    logic                                 r_neg;
    logic [SAMPLE_BITS+FRACTION_BITS-1:0] r_acc;
    logic [SAMPLE_BITS:0]                 w_diff;
    logic [SAMPLE_BITS:0]                 w_abs;
    logic [SAMPLE_BITS-1:0]               w_prod;
    logic [SAMPLE_BITS:0]                 w_delta;
    logic [SAMPLE_BITS:0]                 w_sum;

    assign w_diff = {i_cur[SAMPLE_BITS-1], i_cur} - {i_prev[SAMPLE_BITS-1], i_prev};
    assign w_abs  = w_diff[SAMPLE_BITS] ? -w_diff : w_diff;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mag <= w_abs[SAMPLE_BITS-1:0];
            r_neg <= w_diff[SAMPLE_BITS];
            r_acc <= '0;
        end else if (i_ctl.step) begin
            // MSB-first shift and add, in step with the divider
            r_acc <= {r_acc[SAMPLE_BITS+FRACTION_BITS-2:0], 1'b0}
                     + (i_qbit ? {{FRACTION_BITS{1'b0}}, r_mag} : '0);
        end
    end

    // Work on the magnitude so the shift truncates toward zero
    assign w_prod  = r_acc[SAMPLE_BITS+FRACTION_BITS-1:FRACTION_BITS];
    assign w_delta = r_neg ? -{1'b0, w_prod} : {1'b0, w_prod};
    assign w_sum   = {i_prev[SAMPLE_BITS-1], i_prev} + w_delta;
    assign o_y     = w_sum[SAMPLE_BITS-1:0];

endmodule

FILE: hdl/lir_checker.sv
// Port-level checks of the resampler, bound to the top level.
module lir_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lir_pkg::DATA_BITS-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);

    // a stalled output frame holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output frame changed while stalled");

    // one source frame at a time: ready drops after a request
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("source request taken while busy");

    // reset leaves no output frame pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a new frame is only produced while a source frame is at work
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid ##1 m_axis_tvalid |-> $past(!s_axis_tready))
        else $error("output frame appeared while idle");

endmodule

bind linear_interp_audio_resampler lir_checker u_lir_checker (.*);

FILE: tb/linear_interp_audio_resampler_test.sv
// Self-checking testbench: stereo frames in, predicted interpolated frames checked out.
`timescale 1ns / 1ps

module linear_interp_audio_resampler_test;
    import lir_pkg::*;

    // One predicted output frame
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] right;
        logic                   last;
    } t_out_frame;

    // Tracks the converter's rates, position and stored frame, and holds the
    // output frames that the accepted source frames must still produce.
    class t_resampler_scoreboard;
        logic [RATE_BITS-1:0]   in_rate;
        logic [RATE_BITS-1:0]   out_rate;
        logic                   mono;
        logic [POS_BITS-1:0]    position;
        logic [SAMPLE_BITS-1:0] prev_left;
        logic [SAMPLE_BITS-1:0] prev_right;
        t_out_frame             pending_frames[$];
        int                     mismatches;

        function new();
            in_rate    = IN_RATE_RST;
            out_rate   = OUT_RATE_RST;
            mono       = 1'b0;
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            position   = '0;
            prev_left  = '0;
            prev_right = '0;
        endfunction

        // Any write to a known register wipes position and the stored frame
        function void write_reg(logic [CFG_IDX_BITS-1:0] index, logic [RATE_BITS-1:0] data);
            case (index)
                CFG_IN_RATE:   in_rate = data;
                CFG_OUT_RATE:  out_rate = data;
                CFG_MONO_MODE: mono = data[0];
                default:       return;
            endcase
            clear_state();
        endfunction

        // prev + (cur - prev) * frac / 2^FRACTION_BITS, division toward zero
        function logic [SAMPLE_BITS-1:0] blend(logic [SAMPLE_BITS-1:0] a,
                                               logic [SAMPLE_BITS-1:0] b, longint frac);
            longint base;
            longint diff;
            base = longint'($signed(a));
            diff = longint'($signed(b)) - base;
            return SAMPLE_BITS'(base + (diff * frac) / (longint'(1) << FRACTION_BITS));
        endfunction

        // Note an accepted source frame and queue the output frames it causes
        function void note_frame(logic [SAMPLE_BITS-1:0] left_in,
                                 logic [SAMPLE_BITS-1:0] right_in);
            logic [SAMPLE_BITS-1:0] cur_left;
            logic [SAMPLE_BITS-1:0] cur_right;
            longint                 frac;
            int                     count;
            t_out_frame             frame;
            cur_left  = left_in;
            cur_right = mono ? left_in : right_in;
            count     = 0;
            while (count < RES_CAP && position < out_rate) begin
                frac        = (longint'(position) << FRACTION_BITS) / longint'(out_rate);
                frame.left  = blend(prev_left, cur_left, frac);
                frame.right = blend(prev_right, cur_right, frac);
                count++;
                position    = position + in_rate;
                frame.last  = (count == RES_CAP) || (position >= out_rate);
                pending_frames.push_back(frame);
            end
            // Drop one source period; cap hit with position still short of the target: restart at zero
            if (position >= out_rate)
                position = position - out_rate;
            else
                position = '0;
            prev_left  = cur_left;
            prev_right = cur_right;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one accepted output frame with the oldest prediction
        task check_frame(logic [DATA_BITS-1:0] data, logic last);
            t_out_frame want;
            if (pending_frames.size() == 0) begin
                report($sformatf("output frame %h with nothing predicted", data));
                return;
            end
            want = pending_frames.pop_front();
            if (data[SAMPLE_BITS-1:0] !== want.left)
                report($sformatf("out_left %h, predicted %h",
                                 data[SAMPLE_BITS-1:0], want.left));
            if (data[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.right)
                report($sformatf("out_right %h, predicted %h",
                                 data[2*SAMPLE_BITS-1:SAMPLE_BITS], want.right));
            if (last !== want.last)
                report($sformatf("last_of_run %b, predicted %b", last, want.last));
        endtask

        function int outstanding();
            return pending_frames.size();
        endfunction
    endclass

    localparam int     CLK_HALF   = 6;
    // Settling wait so that a source frame finishes before idle config writes
    localparam int     CFG_SETTLE = 160;
    localparam longint LIMIT_NS   = 64'd7_200_000;
    // Index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [RATE_BITS-1:0]    i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [DATA_BITS-1:0]    s_axis_tdata;   // left_sample, right_sample
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [DATA_BITS-1:0]    m_axis_tdata;   // out_left, out_right
    logic                    m_axis_tlast;   // last_of_run

    t_resampler_scoreboard sb;

    // Idling switches for the source and the sink side
    bit src_gaps;
    bit sink_gaps;
    int stall_left;

    // Last samples sent, used to draw nearby values for smooth signals
    logic [SAMPLE_BITS-1:0] near_left;
    logic [SAMPLE_BITS-1:0] near_right;

    // Extreme sample pairs for the directed part: full swings both ways,
    // zero, -1/+1 and a plain pattern
    logic [SAMPLE_BITS-1:0] extreme_left  [0:7] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                                    16'hFFFF, 16'h0001, 16'h8000, 16'h5A5A};
    logic [SAMPLE_BITS-1:0] extreme_right [0:7] = '{16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF,
                                                    16'h0001, 16'hFFFF, 16'h8000, 16'hA5A5};

    // Fixed rate pairs for the first random phases
    logic [RATE_BITS-1:0] fixed_src  [0:5] = '{16'd44100, 16'd48000, 16'd8000,
                                               16'd48000, 16'd65535, 16'd1};
    logic [RATE_BITS-1:0] fixed_tgt  [0:5] = '{16'd48000, 16'd44100, 16'd48000,
                                               16'd8000, 16'd65535, 16'd65535};
    logic                 fixed_mono [0:5] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    linear_interp_audio_resampler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Sink side: drop tready for random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || !sink_gaps) begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end else begin
            if (stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 19);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Check every output request accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_frame(m_axis_tdata, m_axis_tlast);
    end

    // Mostly nearby values with some full-range and extreme samples mixed in
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [SAMPLE_BITS-1:0] near);
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3, 4: return SAMPLE_BITS'($urandom);
            default: return near + SAMPLE_BITS'($urandom_range(0, 1023)) - 16'd512;
        endcase
    endfunction

    // Mostly audio rates, now and then anything the register holds
    function automatic logic [RATE_BITS-1:0] pick_rate();
        if ($urandom_range(0, 7) == 0)
            return RATE_BITS'($urandom_range(0, 65535));
        return RATE_BITS'($urandom_range(8000, 48000));
    endfunction

    // Send one source frame; return at the edge where the request is taken
    task automatic send_frame(logic [SAMPLE_BITS-1:0] left_in,
                              logic [SAMPLE_BITS-1:0] right_in);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right_in, left_in};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_frame(left_in, right_in);
        near_left  = left_in;
        near_right = right_in;
    endtask

    // Write one register; leaves the write enable high for a following write
    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] index, logic [RATE_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(index, data);
    endtask

    task automatic set_config(logic [RATE_BITS-1:0] rate_in, logic [RATE_BITS-1:0] rate_out,
                              logic [RATE_BITS-1:0] mono_word);
        cfg_write(CFG_IN_RATE, rate_in);
        cfg_write(CFG_OUT_RATE, rate_out);
        cfg_write(CFG_MONO_MODE, mono_word);
        i_cfg_we <= 1'b0;
    endtask

    // Stop sending, wait for every predicted frame, then let a frame
    // that produces nothing finish before anything else happens
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    task automatic run_directed(int first, int count);
        for (int i = 0; i < count; i++)
            send_frame(extreme_left[(first + i) % 8], extreme_right[(first + i) % 8]);
        drain();
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_frame(pick_sample(near_left), pick_sample(near_right));
        drain();
    endtask

    initial begin
        logic [RATE_BITS-1:0] phase_in;
        logic [RATE_BITS-1:0] phase_out;
        logic [RATE_BITS-1:0] mono_word;

        sb = new();
        near_left  = '0;
        near_right = '0;
        src_gaps   = 1'b1;
        sink_gaps  = 1'b1;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset rates: equal rates, each frame replays the stored one
        run_directed(0, 8);

        // Upsampling with full-swing steps between frames
        set_config(16'd11025, 16'd48000, 16'd0);
        run_directed(0, 8);

        // Zero target rate: frames go in, nothing comes out
        set_config(16'd11025, 16'd0, 16'd0);
        run_directed(1, 3);

        // Zero source rate: position stalls, the cap ends each run
        set_config(16'd0, 16'd48000, 16'd0);
        run_directed(2, 3);

        // Heavy downsampling in mono: frames arrive with position past the
        // target; hold junk in the upper mono bits and poke the unused index
        cfg_write(CFG_UNUSED, 16'hFFFF);
        set_config(16'd48000, 16'd8000, 16'hAAAB);
        run_directed(4, 3);

        // Random phases, idling switched on or off per phase
        for (int p = 0; p < 10; p++) begin
            if (p < 6) begin
                phase_in  = fixed_src[p];
                phase_out = fixed_tgt[p];
                mono_word = {RATE_BITS'($urandom_range(0, 65535)) & 16'hFFFE} |
                            RATE_BITS'(fixed_mono[p]);
            end else begin
                phase_in  = pick_rate();
                phase_out = pick_rate();
                mono_word = RATE_BITS'($urandom_range(0, 65535));
            end
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            set_config(phase_in, phase_out, mono_word);
            run_random(28);
        end

        // Last stretch at full speed on both sides
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        set_config(pick_rate(), pick_rate(), RATE_BITS'($urandom_range(0, 1)));
        run_random(40);

        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hard stop if the handshakes hang
    initial begin
        #(LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
